// ----- rtl/iomb_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// iomb_pkg
// Types, codes and helpers shared by the order book cells and the top level.
// ============================================================================
package iomb_pkg;

    localparam int IDX_W = 6;

    typedef struct packed {
        logic        side;
        logic [31:0] order_id;
        logic [31:0] limit_price;
        logic [31:0] total_quantity;
        logic [31:0] peak_size;
    } order_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [31:0] trade_price;
        logic [31:0] trade_quantity;
        logic        last;
    } result_t;

    // scan modes
    localparam logic [1:0] MODE_BEST = 2'd0;
    localparam logic [1:0] MODE_EMIT = 2'd1;
    localparam logic [1:0] MODE_FREE = 2'd2;

    // update operations
    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_FILL   = 2'd2;
    localparam logic [1:0] OP_INSERT = 2'd3;

    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    // record handed along the chain
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [31:0]      price;
        logic [31:0]      age;
        logic [31:0]      visible;
        logic [31:0]      remaining;
        logic [31:0]      acc;
        logic [31:0]      ident;
        logic             acc_zero;
    } rec_t;

    // broadcast control from the sequencer
    typedef struct packed {
        logic [1:0]       mode;
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic             side;
        logic [31:0]      ident;
        logic [31:0]      limit;
        logic [31:0]      amt;
        logic [31:0]      peak;
        logic [IDX_W-1:0] rank;
        logic [31:0]      stamp;
    } ctl_t;

    function automatic logic [31:0] refill_level(input logic [31:0] peak,
                                                 input logic [31:0] rem);
        if (peak == 32'd0 || peak > rem)
            return rem;
        return peak;
    endfunction

endpackage

// ----- rtl/iceberg_order_matching_book.sv -----
`timescale 1ns / 1ps
// ============================================================================
// iceberg_order_matching_book
// Price-time priority limit order book with iceberg orders, built as a
// chain of slot cells scanned by a small sequencer.
// ============================================================================
// Each best-order search, free-slot search and result lookup is one pass of
// the record down the cell chain. An order runs one best-order search per fill
// and one result lookup per trade record, each lookup held by any output stall;
// a residual adds an empty search, a free-slot search, and an insert or a drop.
// One order at a time. Reset clears every slot's valid bit and the sequencer.
module iceberg_order_matching_book #(
    parameter int BOOK_SLOTS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              order_valid,
    output logic              order_stall,
    input  iomb_pkg::order_t  order,
    output logic              result_valid,
    input  logic              result_stall,
    output iomb_pkg::result_t result
);
    import iomb_pkg::*;

    localparam int CNT_W = $clog2(BOOK_SLOTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_RESID = 3'd3;
    localparam logic [2:0] ST_FSCAN = 3'd4;
    localparam logic [2:0] ST_ECHK  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;
    localparam logic [2:0] ST_DROP  = 3'd7;

    logic [2:0]       state_reg;
    logic             ins_reg;
    logic [CNT_W-1:0] cnt_reg;
    order_t           ord_reg;
    logic [31:0]      q_reg;
    logic [IDX_W-1:0] nrank_reg;
    logic [IDX_W-1:0] k_reg;
    logic [31:0]      arrival_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             drop_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    rec_t rec_w [0:BOOK_SLOTS];
    rec_t rec;
    ctl_t ctl;

    logic        done;
    logic        out_free;
    logic [31:0] amt;
    logic        buying;

    assign rec      = rec_w[BOOK_SLOTS];
    assign done     = (cnt_reg == CNT_W'(BOOK_SLOTS));
    assign out_free = !out_valid_reg || !result_stall;
    assign amt      = (rec.visible <= q_reg) ? rec.visible : q_reg;
    assign buying   = !ord_reg.side;

    assign rec_w[0] = '0;

    genvar g;
    generate
        for (g = 0; g < BOOK_SLOTS; g++)
        begin : g_cell
            iomb_cell #(.SLOT(g)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .rin   (rec_w[g]),
                .rout  (rec_w[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        ctl.side  = ord_reg.side;
        ctl.ident = ord_reg.order_id;
        ctl.limit = ord_reg.limit_price;
        ctl.peak  = ord_reg.peak_size;
        ctl.stamp = arrival_reg;
        ctl.mode  = MODE_BEST;
        ctl.op    = OP_NOP;
        ctl.idx   = rec.idx;
        ctl.amt   = amt;
        ctl.rank  = nrank_reg;
        if (ins_reg)
        begin
            ctl.op  = OP_INSERT;
            ctl.idx = free_idx_reg;
            ctl.amt = q_reg;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR: ctl.op = OP_CLEAR;
                ST_SCAN:
                begin
                    if (done && rec.found)
                        ctl.op = OP_FILL;
                end
                ST_FSCAN: ctl.mode = MODE_FREE;
                ST_EMIT:
                begin
                    ctl.mode = MODE_EMIT;
                    ctl.rank = k_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ins_reg       <= 1'b0;
            cnt_reg       <= '0;
            nrank_reg     <= '0;
            k_reg         <= '0;
            arrival_reg   <= 32'd0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !result_stall)
                out_valid_reg <= 1'b0;
            cnt_reg <= done ? cnt_reg : cnt_reg + CNT_W'(1);
            if (ins_reg)
            begin
                ins_reg     <= 1'b0;
                arrival_reg <= arrival_reg + 32'd1;
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (order_valid)
                        begin
                            nrank_reg <= '0;
                            k_reg     <= '0;
                            state_reg <= ST_CLEAR;
                        end
                    end
                    ST_CLEAR:
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (q_reg == 32'd0) ? ST_IDLE : ST_SCAN;
                    end
                    ST_SCAN:
                    begin
                        if (done)
                        begin
                            cnt_reg <= '0;
                            if (rec.found)
                            begin
                                if (rec.acc_zero)
                                    nrank_reg <= nrank_reg + IDX_W'(1);
                                if (rec.visible <= q_reg && rec.remaining != amt)
                                    arrival_reg <= arrival_reg + 32'd1;
                                if (q_reg == amt)
                                    state_reg <= ST_RESID;
                            end
                            else
                                state_reg <= ST_RESID;
                        end
                    end
                    ST_RESID:
                    begin
                        cnt_reg <= '0;
                        if (q_reg == 32'd0)
                        begin
                            drop_reg  <= 1'b0;
                            state_reg <= ST_ECHK;
                        end
                        else
                            state_reg <= ST_FSCAN;
                    end
                    ST_FSCAN:
                    begin
                        if (done)
                        begin
                            drop_reg  <= !rec.found;
                            state_reg <= ST_ECHK;
                        end
                    end
                    ST_ECHK:
                    begin
                        cnt_reg <= '0;
                        if (k_reg < nrank_reg)
                            state_reg <= ST_EMIT;
                        else if (drop_reg)
                            state_reg <= ST_DROP;
                        else
                        begin
                            ins_reg   <= (q_reg != 32'd0);
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_EMIT:
                    begin
                        if (done && out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            k_reg         <= k_reg + IDX_W'(1);
                            state_reg     <= ST_ECHK;
                        end
                    end
                    ST_DROP:
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && !ins_reg && order_valid)
        begin
            ord_reg <= order;
            q_reg   <= order.total_quantity;
        end
        else if (state_reg == ST_SCAN && !ins_reg && done && rec.found)
            q_reg <= q_reg - amt;
        if (state_reg == ST_FSCAN && !ins_reg && done)
            free_idx_reg <= rec.idx;
        if (state_reg == ST_EMIT && !ins_reg && done && out_free)
        begin
            out_reg.kind           <= KIND_TRADE;
            out_reg.buy_id         <= buying ? ord_reg.order_id : rec.ident;
            out_reg.sell_id        <= buying ? rec.ident : ord_reg.order_id;
            out_reg.trade_price    <= rec.price;
            out_reg.trade_quantity <= rec.acc;
            out_reg.last           <= (k_reg == nrank_reg - IDX_W'(1)) && !drop_reg;
        end
        else if (state_reg == ST_DROP && !ins_reg && out_free)
        begin
            out_reg.kind           <= KIND_DROP;
            out_reg.buy_id         <= buying ? ord_reg.order_id : 32'd0;
            out_reg.sell_id        <= buying ? 32'd0 : ord_reg.order_id;
            out_reg.trade_price    <= ord_reg.limit_price;
            out_reg.trade_quantity <= q_reg;
            out_reg.last           <= 1'b1;
        end
    end

    assign order_stall  = (state_reg != ST_IDLE) || ins_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_EMIT || state_reg == ST_DROP))
        else $error("result loaded outside an emitting state");
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nrank_reg <= IDX_W'(BOOK_SLOTS))
        else $error("more fill ranks than slots");
    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_DROP |-> result.last)
        else $error("drop record not marked last");
    a_ins_nodrop: assert property (@(posedge clk) disable iff (!rst_n)
        ins_reg |-> !drop_reg && q_reg != 32'd0)
        else $error("insert with no free slot or no residual");

endmodule

// ----- rtl/iomb_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// iomb_cell
// One book slot: holds a resting order, joins the running scan record and
// applies fill and insert updates addressed to it and the broadcast clear.
// ============================================================================
module iomb_cell #(
    parameter int SLOT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  iomb_pkg::ctl_t ctl,
    input  iomb_pkg::rec_t rin,
    output iomb_pkg::rec_t rout
);
    import iomb_pkg::*;

    logic             valid_reg;
    logic             side_reg;
    logic [31:0]      id_reg;
    logic [31:0]      price_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      vis_reg;
    logic [31:0]      peak_reg;
    logic [31:0]      stamp_reg;
    logic [31:0]      acc_reg;
    logic [IDX_W-1:0] rank_reg;
    rec_t             rout_reg;
    rec_t             rout_next;
    rec_t             own;

    logic [31:0] age;
    logic        elig;
    logic        better;
    logic        hit;
    logic [31:0] new_rem;
    logic [31:0] new_vis;

    assign age     = ctl.stamp - stamp_reg;
    assign hit     = (ctl.idx == IDX_W'(SLOT));
    assign new_rem = rem_reg - ctl.amt;
    assign new_vis = vis_reg - ctl.amt;

    always_comb
    begin
        own.found     = 1'b1;
        own.idx       = IDX_W'(SLOT);
        own.price     = price_reg;
        own.age       = age;
        own.visible   = vis_reg;
        own.remaining = rem_reg;
        own.acc       = acc_reg;
        own.ident     = id_reg;
        own.acc_zero  = (acc_reg == 32'd0);

        elig = valid_reg && (side_reg != ctl.side) &&
               (ctl.side ? (price_reg >= ctl.limit) : (price_reg <= ctl.limit));
        if (!rin.found)
            better = 1'b1;
        else if (price_reg != rin.price)
            better = ctl.side ? (price_reg > rin.price) : (price_reg < rin.price);
        else
            better = (age > rin.age);

        rout_next = rin;
        case (ctl.mode)
            MODE_BEST:
            begin
                if (elig && better)
                    rout_next = own;
            end
            MODE_EMIT:
            begin
                if (!rin.found && acc_reg != 32'd0 && rank_reg == ctl.rank)
                    rout_next = own;
            end
            MODE_FREE:
            begin
                if (!rin.found && !valid_reg)
                    rout_next = own;
            end
            default:
            begin
                rout_next = rin;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rout_reg  <= '0;
        end
        else
        begin
            rout_reg <= rout_next;
            if (ctl.op == OP_FILL && hit && new_vis == 32'd0 && new_rem == 32'd0)
                valid_reg <= 1'b0;
            else if (ctl.op == OP_INSERT && hit)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_CLEAR:
            begin
                acc_reg <= 32'd0;
            end
            OP_FILL:
            begin
                if (hit)
                begin
                    if (acc_reg == 32'd0)
                        rank_reg <= ctl.rank;
                    acc_reg <= acc_reg + ctl.amt;
                    rem_reg <= new_rem;
                    if (new_vis == 32'd0 && new_rem != 32'd0)
                    begin
                        vis_reg   <= refill_level(peak_reg, new_rem);
                        stamp_reg <= ctl.stamp;
                    end
                    else
                        vis_reg <= new_vis;
                end
            end
            OP_INSERT:
            begin
                if (hit)
                begin
                    side_reg  <= ctl.side;
                    id_reg    <= ctl.ident;
                    price_reg <= ctl.limit;
                    rem_reg   <= ctl.amt;
                    peak_reg  <= ctl.peak;
                    vis_reg   <= refill_level(ctl.peak, ctl.amt);
                    stamp_reg <= ctl.stamp;
                    acc_reg   <= 32'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rout = rout_reg;

endmodule

// ----- tb/tb_iceberg_order_matching_book.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_iceberg_order_matching_book
// Drives limit and iceberg orders into the book, predicts the merged trade
// and drop records from a behavioural copy of the book, and checks each
// result transaction in order, under random bursts, gaps and stalls.
// ============================================================================
module tb_iceberg_order_matching_book;
    import iomb_pkg::*;

    localparam int SLOTS       = 32;
    localparam int IDLE_LIMIT  = 400000;
    localparam int LONG_HOLD   = 3000;

    logic    clk;
    logic    rst_n;
    logic    order_valid;
    logic    order_stall;
    order_t  order;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    iceberg_order_matching_book #(.BOOK_SLOTS(SLOTS)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .order_valid  (order_valid),
        .order_stall  (order_stall),
        .order        (order),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // behavioural book
    logic        bk_valid [SLOTS];
    logic        bk_side  [SLOTS];
    logic [31:0] bk_ident [SLOTS];
    logic [31:0] bk_price [SLOTS];
    logic [31:0] bk_rem   [SLOTS];
    logic [31:0] bk_vis   [SLOTS];
    logic [31:0] bk_peak  [SLOTS];
    logic [31:0] bk_stamp [SLOTS];
    logic [31:0] bk_fill  [SLOTS];
    int          bk_rank  [SLOTS];
    logic [31:0] bk_arrival;

    order_t  pending_orders[$];
    result_t expected_trades[$];
    int      errors;
    int      orders_taken;
    int      idle_cycles;
    int      burst_left;
    int      gap_left;
    int      hold_left;
    logic    held;
    logic [8:0] stall_phase;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    function automatic logic [31:0] visible_level(logic [31:0] peak, logic [31:0] rem);
        if (peak == 32'd0 || peak > rem)
            return rem;
        return peak;
    endfunction

    function automatic logic ranks_ahead(int a, int b, logic buying);
        if (bk_price[a] != bk_price[b])
            return buying ? (bk_price[a] < bk_price[b]) : (bk_price[a] > bk_price[b]);
        return (bk_arrival - bk_stamp[a]) > (bk_arrival - bk_stamp[b]);
    endfunction

    function automatic void match_order(order_t o);
        logic              buying;
        logic [31:0]       q;
        logic [31:0]       amt;
        int                nrank;
        int                best;
        int                n;
        int                free_slot;
        logic              uniform;
        longint unsigned   sum;
        longint unsigned   rounds;
        longint unsigned   r;
        result_t           rec;
        buying = (o.side == 1'b0);
        q = o.total_quantity;
        nrank = 0;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            bk_fill[i] = 32'd0;
            bk_rank[i] = 0;
        end
        while (q != 32'd0)
        begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!bk_valid[i] || bk_side[i] == o.side)
                    continue;
                if (buying ? (bk_price[i] > o.limit_price) : (bk_price[i] < o.limit_price))
                    continue;
                if (best < 0 || ranks_ahead(i, best, buying))
                    best = i;
            end
            if (best < 0)
                break;
            uniform = 1'b1;
            sum = 0;
            rounds = 64'hFFFF_FFFF_FFFF_FFFF;
            for (int i = 0; i < SLOTS && uniform; i++)
            begin
                if (!bk_valid[i] || bk_side[i] == o.side || bk_price[i] != bk_price[best])
                    continue;
                if (bk_peak[i] == 0 || bk_vis[i] != bk_peak[i]
                    || 64'(bk_rem[i]) < 2 * 64'(bk_peak[i]) || bk_fill[i] == 0)
                    uniform = 1'b0;
                else
                begin
                    sum += bk_peak[i];
                    if (64'(bk_rem[i]) / 64'(bk_peak[i]) - 1 < rounds)
                        rounds = 64'(bk_rem[i]) / 64'(bk_peak[i]) - 1;
                end
            end
            if (uniform && sum > 0)
            begin
                r = 64'(q) / sum;
                if (rounds < r)
                    r = rounds;
                if (r > 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!bk_valid[i] || bk_side[i] == o.side || bk_price[i] != bk_price[best])
                            continue;
                        amt = 32'(r * bk_peak[i]);
                        bk_fill[i] += amt;
                        bk_rem[i] -= amt;
                    end
                    q -= 32'(r * sum);
                    continue;
                end
            end
            amt = (bk_vis[best] <= q) ? bk_vis[best] : q;
            if (bk_fill[best] == 0)
            begin
                bk_rank[best] = nrank;
                nrank++;
            end
            bk_fill[best] += amt;
            q -= amt;
            bk_rem[best] -= amt;
            bk_vis[best] -= amt;
            if (bk_vis[best] == 0)
            begin
                if (bk_rem[best] == 0)
                    bk_valid[best] = 1'b0;
                else
                begin
                    bk_vis[best] = visible_level(bk_peak[best], bk_rem[best]);
                    bk_stamp[best] = bk_arrival;
                    bk_arrival++;
                end
            end
        end
        for (int k = 0; k < nrank; k++)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (bk_fill[i] == 0 || bk_rank[i] != k)
                    continue;
                rec.kind           = KIND_TRADE;
                rec.buy_id         = buying ? o.order_id : bk_ident[i];
                rec.sell_id        = buying ? bk_ident[i] : o.order_id;
                rec.trade_price    = bk_price[i];
                rec.trade_quantity = bk_fill[i];
                rec.last           = 1'b0;
                expected_trades.push_back(rec);
                n++;
                break;
            end
        end
        if (q != 0)
        begin
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!bk_valid[i])
                begin
                    free_slot = i;
                    break;
                end
            end
            if (free_slot >= 0)
            begin
                bk_valid[free_slot] = 1'b1;
                bk_side[free_slot]  = o.side;
                bk_ident[free_slot] = o.order_id;
                bk_price[free_slot] = o.limit_price;
                bk_rem[free_slot]   = q;
                bk_peak[free_slot]  = o.peak_size;
                bk_vis[free_slot]   = visible_level(o.peak_size, q);
                bk_stamp[free_slot] = bk_arrival;
                bk_arrival++;
            end
            else
            begin
                rec.kind           = KIND_DROP;
                rec.buy_id         = buying ? o.order_id : 32'd0;
                rec.sell_id        = buying ? 32'd0 : o.order_id;
                rec.trade_price    = o.limit_price;
                rec.trade_quantity = q;
                rec.last           = 1'b0;
                expected_trades.push_back(rec);
                n++;
            end
        end
        if (n > 0)
            expected_trades[expected_trades.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic order_t make_order(logic side, logic [31:0] price, logic [31:0] qty,
                                          logic [31:0] peak);
        order_t o;
        o.side           = side;
        o.order_id       = $urandom;
        o.limit_price    = price;
        o.total_quantity = qty;
        o.peak_size      = peak;
        return o;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_valid <= 1'b0;
            order       <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end
        else if (!order_valid || !order_stall)
        begin
            if (gap_left != 0)
            begin
                order_valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end
            else if (pending_orders.size() != 0)
            begin
                order       <= pending_orders.pop_front();
                order_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 10);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                order_valid <= 1'b0;
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
            held         <= 1'b0;
            stall_phase  <= '0;
        end
        else if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (!held && orders_taken >= 40)
        begin
            held         <= 1'b1;
            hold_left    <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            case (stall_phase[8:7])
                2'd0: result_stall <= 1'b0;
                2'd1: result_stall <= 1'($urandom_range(0, 1));
                2'd2: result_stall <= (stall_phase[1:0] != 2'd0);
                default: result_stall <= (stall_phase[3:0] == 4'd0);
            endcase
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (order_valid && !order_stall)
            begin
                match_order(order);
                orders_taken++;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_trades.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    result_t e;
                    e = expected_trades.pop_front();
                    check_field("kind", 32'(e.kind), 32'(result.kind));
                    check_field("buy_id", e.buy_id, result.buy_id);
                    check_field("sell_id", e.sell_id, result.sell_id);
                    check_field("trade_price", e.trade_price, result.trade_price);
                    check_field("trade_quantity", e.trade_quantity, result.trade_quantity);
                    check_field("last", 32'(e.last), 32'(result.last));
                end
            end
            if ((order_valid && !order_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [1:0] stage;
        logic       s;
        errors       = 0;
        orders_taken = 0;
        idle_cycles  = 0;
        bk_arrival   = 32'd0;
        for (int i = 0; i < SLOTS; i++)
            bk_valid[i] = 1'b0;
        rst_n <= 1'b0;

        // directed
        pending_orders.push_back(make_order(1'b0, 32'd100, 32'd50, 32'd0));
        pending_orders.push_back(make_order(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_orders.push_back(make_order(1'b1, 32'd90, 32'd30, 32'd10));
        pending_orders.push_back(make_order(1'b1, 32'd100, 32'd100, 32'd10));
        pending_orders.push_back(make_order(1'b1, 32'd100, 32'd50, 32'd20));
        pending_orders.push_back(make_order(1'b0, 32'd100, 32'd75, 32'd0));
        pending_orders.push_back(make_order(1'b0, 32'd100, 32'd0, 32'd0));
        pending_orders.push_back(make_order(1'b0, 32'd99, 32'd40, 32'd500));
        pending_orders.push_back(make_order(1'b1, 32'd0, 32'd25, 32'd0));
        pending_orders.push_back(make_order(1'b0, 32'hFFFF_FFFF, 32'd60, 32'd0));
        pending_orders.push_back(make_order(1'b1, 32'd0, 32'd10, 32'd3));
        pending_orders.push_back(make_order(1'b0, 32'd0, 32'd4, 32'd0));
        pending_orders.push_back(make_order(1'b0, 32'd200, 32'd90, 32'd30));
        pending_orders.push_back(make_order(1'b0, 32'd200, 32'd60, 32'd20));
        pending_orders.push_back(make_order(1'b1, 32'd150, 32'd170, 32'd0));
        pending_orders.push_back(make_order(1'b1, 32'd0, 32'd1, 32'd0));
        pending_orders.push_back(make_order(1'b0, 32'hFFFF_FFFF, 32'd3, 32'd1));

        // random: crossing, book build-up to full, deep sweeps, mixed
        for (int i = 0; i < 100; i++)
        begin
            stage = 2'(i / 25);
            s = 1'($urandom_range(0, 1));
            case (stage)
                2'd0: pending_orders.push_back(make_order(s,
                          32'($urandom_range(992, 1008)), 32'($urandom_range(1, 300)),
                          ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(10, 100))));
                2'd1: pending_orders.push_back(make_order(s,
                          s ? 32'($urandom_range(3000, 3020)) : 32'($urandom_range(100, 120)),
                          32'($urandom_range(20, 400)),
                          ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(10, 100))));
                2'd2: pending_orders.push_back(make_order(s,
                          s ? 32'($urandom_range(50, 115)) : 32'($urandom_range(3005, 5000)),
                          32'($urandom_range(100, 1000)),
                          ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(10, 100))));
                default: pending_orders.push_back(make_order(s,
                          32'($urandom_range(990, 1010)), 32'($urandom_range(1, 500)),
                          ($urandom_range(0, 2) == 0) ? 32'($urandom_range(10, 600)) : 32'd0));
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_orders.size() != 0 || order_valid)
            @(posedge clk);
        while (expected_trades.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
